// File: sv/assert_macros.svh
// assertion macros for the cache checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every cycle outside reset
`define CHK_IMPLY(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m failed");
// next-cycle implication
`define CHK_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m failed");
`endif

// File: sv/twc_pkg.sv
// package with constants and types of the cache unit
`timescale 1ns / 1ps
package twc_pkg;
  localparam int SetCountDef  = 32;
  localparam int LineBytesDef = 16;
  localparam int AddrBitsDef  = 16;
  localparam int HalfBits     = 16;

  localparam logic CmdRead  = 1'b0;
  localparam logic CmdWrite = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EVICT,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_DONE
  } bk_state_t;
endpackage

// File: sv/twc_front.sv
// front end: request queue with misaligned classification
`timescale 1ns / 1ps
module twc_front import twc_pkg::*; #(
  parameter int AddrBits = AddrBitsDef,
  parameter int LineBytes = LineBytesDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_cmd,
  input  logic [AddrBits-1:0] in_addr,
  input  logic [HalfBits-1:0] in_wval,
  output logic                q_valid,
  input  logic                q_pop,
  output logic                q_cmd,
  output logic [AddrBits-1:0] q_addr,
  output logic [HalfBits-1:0] q_wval,
  output logic                q_mis
);
  localparam int OffBits = $clog2(LineBytes);
  localparam int EntW = 2 + AddrBits + HalfBits;
  logic [EntW-1:0] fifo [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic push, mis;

  assign mis = (in_addr[OffBits-1:0] == OffBits'(LineBytes - 1));
  assign in_stall = (cnt == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt != 2'd0);
  assign {q_mis, q_cmd, q_addr, q_wval} = fifo[rp];

  always_ff @(posedge clk) begin
    if (push) fifo[wp] <= {mis, in_cmd, in_addr, in_wval};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (q_pop) rp <= !rp;
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end
endmodule

// File: sv/twc_back.sv
// back end: tag check, eviction, refill, data access and result register
`timescale 1ns / 1ps
module twc_back import twc_pkg::*; #(
  parameter int SetCount = SetCountDef,
  parameter int LineBytes = LineBytesDef,
  parameter int AddrBits = AddrBitsDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_pop,
  input  logic                q_cmd,
  input  logic [AddrBits-1:0] q_addr,
  input  logic [HalfBits-1:0] q_wval,
  input  logic                q_mis,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [HalfBits-1:0] out_data,
  output logic                out_hit,
  output logic                out_wb,
  output logic                out_mis
);
  localparam int OffBits  = $clog2(LineBytes);
  localparam int SetBits  = $clog2(SetCount);
  localparam int TagBits  = AddrBits - OffBits - SetBits;
  localparam int LineW    = 8 * LineBytes;
  localparam int LineAddr = AddrBits - OffBits;
  localparam int MemDepth = 1 << LineAddr;
  localparam int CBits    = LineAddr + 1;

  logic [LineW-1:0]   dmem [2*SetCount];
  logic [TagBits-1:0] tmem [2*SetCount];
  logic [LineW-1:0]   bmem [MemDepth];
  logic [2*SetCount-1:0] vld, drt;
  logic [SetCount-1:0] vic;

  bk_state_t state, state_next;
  logic [CBits-1:0] clr;
  logic cmd;
  logic [AddrBits-1:0] addr;
  logic [HalfBits-1:0] wval;
  logic [LineW-1:0] line0, line1, mline;
  logic [TagBits-1:0] tag0, tag1;
  logic hit, wb, way;
  logic [TagBits-1:0] tg;
  logic [SetBits-1:0] st;
  logic [OffBits-1:0] off;
  logic h0, h1, full, vw;
  logic [LineW-1:0] wline, nline;
  logic [HalfBits-1:0] rdata;
  logic [SetBits:0] i0, i1, iw;
  logic [LineAddr-1:0] vaddr;

  assign tg  = addr[AddrBits-1 -: TagBits];
  assign st  = addr[OffBits +: SetBits];
  assign off = addr[OffBits-1:0];
  assign i0 = {st, 1'b0};
  assign i1 = {st, 1'b1};
  assign h0 = vld[i0] && tag0 == tg;
  assign h1 = vld[i1] && tag1 == tg;
  assign full = vld[i0] && vld[i1];
  assign vw = vic[st];
  assign iw = {st, way};
  assign wline = way ? line1 : line0;
  assign vaddr = {(vw ? tag1 : tag0), st};

  always_comb begin
    nline = wline;
    rdata = {wline[LineW-1-8*off -: 8], wline[LineW-9-8*off -: 8]};
    if (cmd == CmdWrite) begin
      nline[LineW-1-8*off -: 8] = wval[15:8];
      nline[LineW-9-8*off -: 8] = wval[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid && !q_mis) begin
      line0 <= dmem[{q_addr[OffBits +: SetBits], 1'b0}];
      line1 <= dmem[{q_addr[OffBits +: SetBits], 1'b1}];
      tag0  <= tmem[{q_addr[OffBits +: SetBits], 1'b0}];
      tag1  <= tmem[{q_addr[OffBits +: SetBits], 1'b1}];
    end
    if (state == ST_EVICT && drt[{st, vw}]) bmem[vaddr] <= vw ? line1 : line0;
    if (clr[CBits-1] == 1'b0) bmem[clr[LineAddr-1:0]] <= '0;
    if (state == ST_FILL_RD) mline <= bmem[addr[AddrBits-1:OffBits]];
    if (state == ST_FILL_WR) begin
      if (way) line1 <= mline;
      else line0 <= mline;
      tmem[iw] <= tg;
    end
    if (state == ST_DONE && !(out_valid && out_stall)) dmem[iw] <= nline;
    if (state == ST_IDLE && q_valid) begin
      cmd <= q_cmd;
      addr <= q_addr;
      wval <= q_wval;
    end
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    case (state)
      ST_IDLE:    if (q_valid && clr[CBits-1] && !(out_valid && out_stall)) begin
        q_pop = 1'b1;
        state_next = q_mis ? ST_IDLE : ST_LOOKUP;
      end
      ST_LOOKUP:  state_next = (h0 || h1) ? ST_DONE : (full ? ST_EVICT : ST_FILL_RD);
      ST_EVICT:   state_next = ST_FILL_RD;
      ST_FILL_RD: state_next = ST_FILL_WR;
      ST_FILL_WR: state_next = ST_DONE;
      ST_DONE:    if (!(out_valid && out_stall)) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      clr <= '0;
      vld <= '0;
      drt <= '0;
      vic <= '0;
      out_valid <= 1'b0;
      hit <= 1'b0;
      wb <= 1'b0;
      way <= 1'b0;
    end else begin
      state <= state_next;
      if (clr[CBits-1] == 1'b0) clr <= clr + CBits'(1);
      if ((state == ST_IDLE && q_pop && q_mis) ||
          (state == ST_DONE && !(out_valid && out_stall))) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        ST_IDLE: if (q_pop && q_mis) begin
          out_data <= '0;
          out_hit <= 1'b0;
          out_wb <= 1'b0;
          out_mis <= 1'b1;
        end
        ST_LOOKUP: begin
          hit <= h0 || h1;
          wb <= 1'b0;
          way <= h0 ? 1'b0 : (h1 ? 1'b1 : (full ? vw : vld[i0]));
        end
        ST_EVICT: begin
          wb <= drt[{st, vw}];
          vld[{st, vw}] <= 1'b0;
          drt[{st, vw}] <= 1'b0;
          way <= vw ? 1'b1 : 1'b0;
        end
        ST_FILL_WR: begin
          vld[iw] <= 1'b1;
          drt[iw] <= 1'b0;
        end
        ST_DONE: if (!(out_valid && out_stall)) begin
          vic[st] <= !way;
          if (cmd == CmdWrite) drt[iw] <= 1'b1;
          out_data <= (cmd == CmdWrite) ? '0 : rdata;
          out_hit <= hit;
          out_wb <= wb;
          out_mis <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule

// File: sv/two_way_writeback_cache_unit.sv
// Two-way set-associative write-back cache over an internal backing memory.
// A request is handled by the back-end sequencer that reads tags and lines,
// writes back a dirty victim, fetches the line from the single-port backing
// memory and updates the way. After reset the backing memory is cleared
// before any request is served. A two-entry queue decouples the input from
// the back end.
`timescale 1ns / 1ps
module two_way_writeback_cache_unit import twc_pkg::*; #(
  parameter int SET_COUNT = SetCountDef,
  parameter int LINE_BYTES = LineBytesDef,
  parameter int ADDR_BITS = AddrBitsDef
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 cmd,
  input  logic [ADDR_BITS-1:0] address,
  input  logic [HalfBits-1:0]  write_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [HalfBits-1:0]  read_data,
  output logic                 was_hit,
  output logic                 wrote_back,
  output logic                 misaligned
);
  logic q_valid, q_pop, q_cmd, q_mis;
  logic [ADDR_BITS-1:0] q_addr;
  logic [HalfBits-1:0] q_wval;

  twc_front #(.AddrBits(ADDR_BITS), .LineBytes(LINE_BYTES)) u_front (
    .clk, .rst, .in_valid, .in_stall, .in_cmd(cmd), .in_addr(address),
    .in_wval(write_value), .q_valid, .q_pop, .q_cmd, .q_addr, .q_wval, .q_mis
  );

  twc_back #(.SetCount(SET_COUNT), .LineBytes(LINE_BYTES), .AddrBits(ADDR_BITS)) u_back (
    .clk, .rst, .q_valid, .q_pop, .q_cmd, .q_addr, .q_wval, .q_mis,
    .out_valid, .out_stall, .out_data(read_data), .out_hit(was_hit),
    .out_wb(wrote_back), .out_mis(misaligned)
  );
endmodule

// File: sv/twc_checker.sv
// port-level checker for the cache unit
`timescale 1ns / 1ps
`include "assert_macros.svh"
module twc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] read_data,
  input logic        was_hit,
  input logic        wrote_back,
  input logic        misaligned
);
  `CHK_IMPLY(a_mis_clean, clk, rst, out_valid && misaligned, read_data == 16'd0 && !was_hit && !wrote_back)
  `CHK_IMPLY(a_hit_no_wb, clk, rst, out_valid && was_hit, !wrote_back)
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(read_data))
endmodule

bind two_way_writeback_cache_unit twc_checker u_chk (
  .clk, .rst, .out_valid, .out_stall, .read_data, .was_hit, .wrote_back, .misaligned
);
